[hdl/alts_pkg.sv]
// Shared codes and fixed constants for the acceleration-limited trajectory stepper.
// Used by accel_limited_trajectory_step; depends on nothing.
`timescale 1ns / 1ps

package alts_pkg;

  // Item kind carried in tuser
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd2;

  // Reset value of the time step register (about 10 ms at 16 fraction bits)
  localparam int unsigned DT_RESET = 655;

  // Wide intermediate format and square-root sizes
  localparam int unsigned XW     = 64;
  localparam int unsigned ROOT_W = 32;
  localparam logic [XW-1:0] ONES64 = {XW{1'b1}};

  // Operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    U_MUL,
    U_DIV,
    U_SQRT
  } unit_op_e;

endpackage

[hdl/accel_limited_trajectory_step.sv]
// Acceleration-limited 3D trajectory stepper: state, sequencer and shared unit.
// Depends on alts_pkg.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid_i/tready_o     | tdata goal x,y,z, load_vel x,y,z; tuser op
// m_axis   | out | m_axis_tvalid_o/tready_i     | tdata pos x,y,z, vel x,y,z, acc x,y,z;
//          |     |                              | tuser snapped
// cfg      | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// A step word runs up to 29 multiplies on a bit-serial shift-add unit, up to 9 divides
// (restoring, one quotient bit a cycle) and 5 square roots, all on one shared unit
// under the sequencer. A load word skips the arithmetic and goes straight to the done state.
// Reset clears position and velocity to zero and sets the registers to their defaults.
// s_axis_tready_o is high only while idle; a finished word waits in the output register
// and the sequencer holds its last state until that register is free.

module accel_limited_trajectory_step #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // goal_x, goal_y, goal_z, load_vel_x, load_vel_y, load_vel_z (low bits first)
  input  logic [((6*WORD_BITS+7)/8)*8-1:0]            s_axis_tdata_i,
  // op
  input  logic [0:0]                                  s_axis_tuser_i,
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z (low bits first)
  output logic [((9*WORD_BITS+7)/8)*8-1:0]            m_axis_tdata_o,
  // snapped
  output logic [0:0]                                  m_axis_tuser_o,
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [alts_pkg::CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [WORD_BITS-2:0]                        cfg_data_i
);

  import alts_pkg::*;

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned MW  = W + 1;
  localparam int unsigned PXW = (2 * W + 2 > XW + 1) ? 2 * W + 2 : XW + 1;
  localparam int unsigned OW  = ((9 * W + 7) / 8) * 8;
  localparam logic [XW-1:0] MAG64 = (XW'(1) << (W - 1)) - XW'(1);
  localparam logic [XW-1:0] MIN64 = XW'(1) << (W - 1);
  localparam logic [MW-1:0] ONE_QM = MW'(1) << F;
  localparam int unsigned DT_FLOOR_I = ((1 << F) + 999) / 1000;
  localparam logic [W-2:0] DT_FLOOR = (W-1)'(DT_FLOOR_I);
  localparam logic [W-2:0] MAGW = {(W-1){1'b1}};

  typedef enum logic [4:0] {
    ST_IDLE, ST_ERR, ST_ENORM, ST_ESQRT, ST_VNORM, ST_VSQRT, ST_R1MUL, ST_R1SQRT,
    ST_HMUL, ST_HAMUL, ST_R2MUL, ST_R2SQRT, ST_WMUL, ST_WDIV, ST_LIMMUL, ST_DNMUL,
    ST_DNSQRT, ST_VADJMUL, ST_VADJDIV, ST_ADVMUL, ST_DOTMUL, ST_SNAP, ST_AMUL,
    ST_ADIV, ST_DONE
  } state_e;

  // ---------------------------------------------------------------- helpers
  function automatic logic [W-1:0] mag_w(input logic [W-1:0] x);
    return x[W-1] ? (~x + W'(1)) : x;
  endfunction

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic sub);
    logic [W:0] t;
    t = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (t[W] != t[W-1]) return t[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    return t[W-1:0];
  endfunction

  function automatic logic [W-1:0] with_sign(input logic neg, input logic [XW-1:0] m);
    logic [W-1:0] r;
    if (neg) begin
      r = (m >= MIN64) ? {1'b1, {(W-1){1'b0}}} : (~m[W-1:0] + W'(1));
    end else begin
      r = (m > MAG64) ? {1'b0, {(W-1){1'b1}}} : m[W-1:0];
    end
    return r;
  endfunction

  function automatic logic [W-2:0] mul_q(input logic [XW-1:0] p, input int unsigned sh);
    logic [XW-1:0] t;
    t = p >> sh;
    if (p == ONES64 || t > MAG64) return MAGW;
    return t[W-2:0];
  endfunction

  function automatic logic [W-2:0] clamp_root(input logic [XW-1:0] r);
    if (r > MAG64) return MAGW;
    return r[W-2:0];
  endfunction

  function automatic logic [XW-1:0] add_sat(input logic [XW-1:0] a, input logic [XW-1:0] b);
    logic [XW:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[XW] ? ONES64 : t[XW-1:0];
  endfunction

  // ---------------------------------------------------------------- registers
  state_e state_q;
  logic [1:0] k_q;
  logic [W-2:0] spd_q, acl_q, dt_q;
  logic [W-1:0] pos_q [3];
  logic [W-1:0] vel_q [3];
  logic [W-1:0] goal_q [3];
  logic [W-1:0] err_q [3];
  logic [W-1:0] want_q [3];
  logic [W-1:0] delta_q [3];
  logic [W-1:0] vnew_q [3];
  logic [W-1:0] nxt_q [3];
  logic [W-1:0] acc_q [3];
  logic [XW-1:0] sum_q, p_q, dpos_q, dneg_q;
  logic [W-2:0] e_norm_q, v_norm_q, h_q, m_q, s_q, lim_q, dn_q;
  logic [ROOT_W-1:0] r1_q;
  logic snap_q;
  logic [OW-1:0] out_data_q;
  logic out_snap_q, out_valid_q;

  // shared unit state
  unit_op_e u_op_q;
  logic u_busy_q, u_done_q;
  logic [6:0] u_cnt_q;
  logic [PXW-1:0] u_acc_q, u_mc_q;
  logic [MW-1:0] u_mp_q;
  logic [XW-1:0] u_x_q;
  logic [W-2:0] u_rem_q, u_dv_q;
  logic [ROOT_W+2:0] u_srem_q;
  logic [ROOT_W-1:0] u_root_q;

  // ---------------------------------------------------------------- per-axis views
  logic [W-1:0] a_w, b_w, cur_err, cur_vel, cur_delta, cur_vnew;
  logic [W:0] dvf;
  logic [MW-1:0] dv_mag;
  logic [W-2:0] den;
  logic [XW-1:0] u_res;
  logic [ROOT_W:0] dsum;
  logic [ROOT_W-1:0] dmax;
  logic [XW-1:0] dmax64;
  logic [W-1:0] want_w, add_w;
  logic dot_neg;

  always_comb begin
    cur_err   = err_q[k_q];
    cur_vel   = vel_q[k_q];
    cur_delta = delta_q[k_q];
    cur_vnew  = vnew_q[k_q];
    a_w       = sat_add(nxt_q[k_q], goal_q[k_q], 1'b1);
    b_w       = sat_add(pos_q[k_q], goal_q[k_q], 1'b1);
    dot_neg   = (a_w[W-1] != b_w[W-1]) && (a_w != '0) && (b_w != '0);
    dvf       = {cur_vnew[W-1], cur_vnew} - {cur_vel[W-1], cur_vel};
    dv_mag    = dvf[W] ? (~dvf + MW'(1)) : dvf;
    den       = (dt_q > DT_FLOOR) ? dt_q : DT_FLOOR;
    dsum      = {1'b0, r1_q} + {1'b0, u_res[ROOT_W-1:0]};
    dmax      = dsum[ROOT_W:1];
    dmax64    = XW'(dmax);
  end

  // ---------------------------------------------------------------- unit requests
  logic     calc, skip;
  unit_op_e c_op;
  logic [MW-1:0] c_a, c_b;
  logic [XW-1:0] c_x;
  logic [XW-1:0] q_skip, qv;
  logic u_start, fin;

  always_comb begin
    calc   = 1'b1;
    skip   = 1'b0;
    c_op   = U_MUL;
    c_a    = '0;
    c_b    = '0;
    c_x    = sum_q;
    q_skip = '0;
    case (state_q)
      ST_ENORM: begin
        c_a = MW'(mag_w(cur_err));
        c_b = MW'(mag_w(cur_err));
      end
      ST_VNORM: begin
        c_a = MW'(mag_w(cur_vel));
        c_b = MW'(mag_w(cur_vel));
      end
      ST_DNMUL: begin
        c_a = MW'(mag_w(cur_delta));
        c_b = MW'(mag_w(cur_delta));
      end
      ST_ESQRT, ST_VSQRT, ST_R1SQRT, ST_R2SQRT, ST_DNSQRT: begin
        c_op = U_SQRT;
      end
      ST_R1MUL: begin
        c_a = MW'(e_norm_q);
        c_b = MW'(acl_q);
      end
      ST_HMUL: begin
        c_a = MW'(v_norm_q);
        c_b = MW'(dt_q);
      end
      ST_HAMUL: begin
        c_a = MW'(h_q);
        c_b = MW'(acl_q);
      end
      ST_R2MUL: begin
        c_a = {1'b0, m_q, 1'b0};
        c_b = ONE_QM;
      end
      ST_WMUL: begin
        c_a = MW'(mag_w(cur_err));
        c_b = MW'(s_q);
      end
      ST_LIMMUL: begin
        c_a = MW'(acl_q);
        c_b = MW'(dt_q);
      end
      ST_VADJMUL: begin
        calc = !(dn_q < lim_q);
        c_a  = MW'(mag_w(cur_delta));
        c_b  = MW'(lim_q);
      end
      ST_ADVMUL: begin
        c_a = MW'(mag_w(cur_vnew));
        c_b = MW'(dt_q);
      end
      ST_DOTMUL: begin
        c_a = MW'(mag_w(a_w));
        c_b = MW'(mag_w(b_w));
      end
      ST_AMUL: begin
        c_a = dv_mag;
        c_b = ONE_QM;
      end
      ST_WDIV, ST_VADJDIV, ST_ADIV: begin
        c_op = U_DIV;
        c_x  = p_q;
        case (state_q)
          ST_WDIV:    c_a = MW'(e_norm_q);
          ST_VADJDIV: c_a = MW'(dn_q);
          default:    c_a = MW'(den);
        endcase
        skip   = (c_a == '0) || (p_q == ONES64);
        calc   = !skip;
        q_skip = (c_a == '0) ? '0 : MIN64;
      end
      default: calc = 1'b0;
    endcase
    u_start = calc && !u_busy_q && !u_done_q;
    fin     = skip || u_done_q;
    qv      = skip ? q_skip : u_res;
  end

  // ---------------------------------------------------------------- shared unit
  always_comb begin
    case (u_op_q)
      U_MUL:   u_res = (|u_acc_q[PXW-1:XW]) ? ONES64 : u_acc_q[XW-1:0];
      U_DIV:   u_res = u_x_q;
      default: u_res = XW'(u_root_q);
    endcase
  end

  logic [W-1:0] div_t;
  logic [ROOT_W+2:0] sq_t, sq_trial;

  always_comb begin
    div_t    = {u_rem_q, u_x_q[XW-1]};
    sq_t     = {u_srem_q[ROOT_W:0], u_x_q[XW-1:XW-2]};
    sq_trial = {1'b0, u_root_q, 2'b01};
  end

  // Step the multiplier, divider or square root one bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_busy_q <= 1'b0;
      u_done_q <= 1'b0;
      u_cnt_q  <= '0;
      u_op_q   <= U_MUL;
    end else begin
      u_done_q <= 1'b0;
      if (u_start) begin
        u_busy_q <= 1'b1;
        u_op_q   <= c_op;
        u_acc_q  <= '0;
        u_mc_q   <= PXW'(c_a);
        u_mp_q   <= c_b;
        u_x_q    <= c_x;
        u_rem_q  <= '0;
        u_dv_q   <= c_a[W-2:0];
        u_srem_q <= '0;
        u_root_q <= '0;
        case (c_op)
          U_MUL:   u_cnt_q <= 7'(MW);
          U_DIV:   u_cnt_q <= 7'(XW);
          default: u_cnt_q <= 7'(ROOT_W);
        endcase
      end else if (u_busy_q) begin
        case (u_op_q)
          U_MUL: begin
            if (u_mp_q[0]) u_acc_q <= u_acc_q + u_mc_q;
            u_mc_q <= u_mc_q << 1;
            u_mp_q <= u_mp_q >> 1;
          end
          U_DIV: begin
            if (div_t >= {1'b0, u_dv_q}) begin
              u_rem_q <= (div_t - {1'b0, u_dv_q}) >> 0 == '0 ? '0 :
                         W'(div_t - {1'b0, u_dv_q}) >> 0 >= '0 ?
                         (W-1)'(div_t - {1'b0, u_dv_q}) : '0;
              u_x_q   <= {u_x_q[XW-2:0], 1'b1};
            end else begin
              u_rem_q <= div_t[W-2:0];
              u_x_q   <= {u_x_q[XW-2:0], 1'b0};
            end
          end
          default: begin
            if (sq_t >= sq_trial) begin
              u_srem_q <= sq_t - sq_trial;
              u_root_q <= {u_root_q[ROOT_W-2:0], 1'b1};
            end else begin
              u_srem_q <= sq_t;
              u_root_q <= {u_root_q[ROOT_W-2:0], 1'b0};
            end
            u_x_q <= u_x_q << 2;
          end
        endcase
        u_cnt_q <= u_cnt_q - 7'd1;
        if (u_cnt_q == 7'd1) begin
          u_busy_q <= 1'b0;
          u_done_q <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- output packing
  logic [OW-1:0] out_d;
  always_comb begin
    out_d = '0;
    for (int i = 0; i < 3; i++) begin
      out_d[i*W +: W]       = snap_q ? goal_q[i] : nxt_q[i];
      out_d[(3+i)*W +: W]   = snap_q ? '0 : vnew_q[i];
      out_d[(6+i)*W +: W]   = acc_q[i];
    end
    want_w = with_sign(cur_err[W-1], qv);
    add_w  = with_sign(cur_delta[W-1], qv);
  end

  assign s_axis_tready_o   = (state_q == ST_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_snap_q;
  assign m_axis_tvalid_o   = out_valid_q;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      spd_q       <= (W-1)'(1) << F;
      acl_q       <= (W-1)'(1) << F;
      dt_q        <= (W-1)'(DT_RESET);
      out_valid_q <= 1'b0;
      out_snap_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else begin
      // take configuration writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SPEED: spd_q <= cfg_data_i;
          CFG_ACCEL: acl_q <= cfg_data_i;
          CFG_STEP:  dt_q  <= cfg_data_i;
          default: ;
        endcase
      end
      // drop the output word once taken
      if (out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            for (int i = 0; i < 3; i++) begin
              goal_q[i] <= s_axis_tdata_i[i*W +: W];
              nxt_q[i]  <= s_axis_tdata_i[i*W +: W];
              vnew_q[i] <= s_axis_tdata_i[(3+i)*W +: W];
              acc_q[i]  <= '0;
            end
            snap_q <= 1'b0;
            k_q    <= '0;
            state_q <= (s_axis_tuser_i[0] == OP_LOAD) ? ST_DONE : ST_ERR;
          end
        end
        ST_ERR: begin
          for (int i = 0; i < 3; i++) err_q[i] <= sat_add(goal_q[i], pos_q[i], 1'b1);
          sum_q   <= '0;
          state_q <= ST_ENORM;
        end
        ST_ENORM, ST_VNORM, ST_DNMUL: begin
          if (u_done_q) begin
            sum_q <= add_sat(sum_q, u_res);
            if (k_q == 2'd2) begin
              k_q <= '0;
              case (state_q)
                ST_ENORM: state_q <= ST_ESQRT;
                ST_VNORM: state_q <= ST_VSQRT;
                default:  state_q <= ST_DNSQRT;
              endcase
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        ST_ESQRT: begin
          if (u_done_q) begin
            e_norm_q <= clamp_root(u_res);
            sum_q    <= '0;
            state_q  <= ST_VNORM;
          end
        end
        ST_VSQRT: begin
          if (u_done_q) begin
            v_norm_q <= clamp_root(u_res);
            state_q  <= ST_R1MUL;
          end
        end
        ST_R1MUL: begin
          if (u_done_q) begin
            sum_q   <= add_sat(u_res, u_res);
            state_q <= ST_R1SQRT;
          end
        end
        ST_R1SQRT: begin
          if (u_done_q) begin
            r1_q    <= u_res[ROOT_W-1:0];
            state_q <= ST_HMUL;
          end
        end
        ST_HMUL: begin
          if (u_done_q) begin
            h_q     <= mul_q(u_res, F + 1);
            state_q <= ST_HAMUL;
          end
        end
        ST_HAMUL: begin
          if (u_done_q) begin
            m_q <= (e_norm_q > mul_q(u_res, F)) ? (e_norm_q - mul_q(u_res, F)) : '0;
            state_q <= ST_R2MUL;
          end
        end
        ST_R2MUL: begin
          if (u_done_q) begin
            sum_q   <= u_res;
            state_q <= ST_R2SQRT;
          end
        end
        ST_R2SQRT: begin
          // cap the speed by the deceleration bound
          if (u_done_q) begin
            s_q     <= (XW'(spd_q) < dmax64) ? spd_q : dmax64[W-2:0];
            k_q     <= '0;
            state_q <= ST_WMUL;
          end
        end
        ST_WMUL: begin
          if (u_done_q) begin
            p_q     <= u_res;
            state_q <= ST_WDIV;
          end
        end
        ST_WDIV: begin
          if (fin) begin
            want_q[k_q]  <= want_w;
            delta_q[k_q] <= sat_add(want_w, cur_vel, 1'b1);
            if (k_q == 2'd2) begin
              k_q     <= '0;
              state_q <= ST_LIMMUL;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_WMUL;
            end
          end
        end
        ST_LIMMUL: begin
          if (u_done_q) begin
            lim_q   <= mul_q(u_res, F);
            sum_q   <= '0;
            state_q <= ST_DNMUL;
          end
        end
        ST_DNSQRT: begin
          if (u_done_q) begin
            dn_q    <= clamp_root(u_res);
            k_q     <= '0;
            state_q <= ST_VADJMUL;
          end
        end
        ST_VADJMUL: begin
          // within the limit the wanted velocity is taken as it is
          if (!calc) begin
            vnew_q[k_q] <= want_q[k_q];
            if (k_q == 2'd2) begin
              k_q     <= '0;
              dpos_q  <= '0;
              dneg_q  <= '0;
              state_q <= ST_ADVMUL;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end else if (u_done_q) begin
            p_q     <= u_res;
            state_q <= ST_VADJDIV;
          end
        end
        ST_VADJDIV: begin
          if (fin) begin
            vnew_q[k_q] <= sat_add(cur_vel, add_w, 1'b0);
            if (k_q == 2'd2) begin
              k_q     <= '0;
              dpos_q  <= '0;
              dneg_q  <= '0;
              state_q <= ST_ADVMUL;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_VADJMUL;
            end
          end
        end
        ST_ADVMUL: begin
          if (u_done_q) begin
            nxt_q[k_q] <= sat_add(pos_q[k_q],
                                  with_sign(cur_vnew[W-1], XW'(mul_q(u_res, F))), 1'b0);
            state_q    <= ST_DOTMUL;
          end
        end
        ST_DOTMUL: begin
          // accumulate the dot product of old and new error by sign
          if (u_done_q) begin
            if (dot_neg) dneg_q <= add_sat(dneg_q, u_res);
            else         dpos_q <= add_sat(dpos_q, u_res);
            if (k_q == 2'd2) begin
              k_q     <= '0;
              state_q <= ST_SNAP;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_ADVMUL;
            end
          end
        end
        ST_SNAP: begin
          snap_q  <= (dneg_q > dpos_q);
          state_q <= ST_AMUL;
        end
        ST_AMUL: begin
          if (u_done_q) begin
            p_q     <= u_res;
            state_q <= ST_ADIV;
          end
        end
        ST_ADIV: begin
          if (fin) begin
            acc_q[k_q] <= with_sign(dvf[W], qv);
            if (k_q == 2'd2) begin
              k_q     <= '0;
              state_q <= ST_DONE;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_AMUL;
            end
          end
        end
        ST_DONE: begin
          // hold until the output register is free, then commit the state
          if (!out_valid_q || m_axis_tready_i) begin
            out_data_q  <= out_d;
            out_snap_q  <= snap_q;
            out_valid_q <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              pos_q[i] <= out_d[i*W +: W];
              vel_q[i] <= out_d[(3+i)*W +: W];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[tb/sv/tb_accel_limited_trajectory_step.sv]
// Self-checking bench for accel_limited_trajectory_step: random and directed step/load
// words, bursty sender, stalling receiver, built-in Q16.16 trajectory predictor.
// Depends on alts_pkg and the block itself.
`timescale 1ns / 1ps

module tb_accel_limited_trajectory_step;
  import alts_pkg::*;

  localparam int unsigned FB = 16;
  localparam int unsigned WB = 32;
  localparam longint unsigned MAGMAX = 64'h7FFF_FFFF;
  localparam longint unsigned U64MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint unsigned DT_MIN = 66;
  localparam int unsigned HOLD_CYCLES = 6000;

  typedef struct packed {
    logic             op;
    logic [5:0][31:0] val;  // goal x,y,z then load velocity x,y,z
  } stim_word_t;

  typedef struct packed {
    logic [8:0][31:0] val;  // pos, vel, acc
    logic             snap;
  } motion_t;

  logic clk_i, rst_ni;
  logic [191:0] s_axis_tdata_i;
  logic [0:0]   s_axis_tuser_i;
  logic         s_axis_tvalid_i, s_axis_tready_o;
  logic [287:0] m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;
  logic         m_axis_tvalid_o, m_axis_tready_i;
  logic         cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [30:0]  cfg_data_i;

  accel_limited_trajectory_step i_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata_i, .s_axis_tuser_i, .s_axis_tvalid_i, .s_axis_tready_o,
    .m_axis_tdata_o, .m_axis_tuser_o, .m_axis_tvalid_o, .m_axis_tready_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  stim_word_t pending_words[$];
  motion_t    expected_motion[$];
  int         fail_cnt = 0;
  int         hold_reqs = 0;

  // Predictor state and register copies
  longint          pos_m[3], vel_m[3];
  longint unsigned speed_m, accel_m, dt_m;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic longint sat_w(longint x);
    if (x > longint'(MAGMAX)) return longint'(MAGMAX);
    if (x < -longint'(MAGMAX) - 1) return -longint'(MAGMAX) - 1;
    return x;
  endfunction

  function automatic longint unsigned mag(longint x);
    return x < 0 ? 64'd0 - longint'(x) : longint'(x);
  endfunction

  function automatic longint signed_of(bit neg, longint unsigned m);
    longint r;
    if (m > MAGMAX + 1) m = MAGMAX + 1;
    r = longint'(m);
    return sat_w(neg ? -r : r);
  endfunction

  function automatic longint unsigned mul_wide(longint unsigned a, longint unsigned b);
    if (a != 0 && b > U64MAX / a) return U64MAX;
    return a * b;
  endfunction

  function automatic longint unsigned add_wide(longint unsigned a, longint unsigned b);
    return (a > U64MAX - b) ? U64MAX : a + b;
  endfunction

  function automatic longint unsigned mul_fix(longint unsigned a, longint unsigned b,
                                              int sh);
    longint unsigned p;
    p = mul_wide(a, b);
    if (p == U64MAX) return MAGMAX;
    p = p >> sh;
    return p > MAGMAX ? MAGMAX : p;
  endfunction

  function automatic longint unsigned scale_ratio(longint unsigned a, longint unsigned b,
                                                  longint unsigned c);
    longint unsigned p;
    if (c == 0) return 0;
    p = mul_wide(a, b);
    if (p == U64MAX) return MAGMAX + 1;
    return p / c;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned length3(longint a, longint b, longint c);
    longint unsigned s, r;
    s = add_wide(add_wide(mul_wide(mag(a), mag(a)), mul_wide(mag(b), mag(b))),
                 mul_wide(mag(c), mag(c)));
    r = root_floor(s);
    return r > MAGMAX ? MAGMAX : r;
  endfunction

  // Apply one word to the predictor state and give the result it must produce
  function automatic motion_t advance_trajectory(stim_word_t w);
    motion_t res;
    longint goal[3], err[3], want[3], dv[3], vn[3], nxt[3], acc[3];
    longint a, b, adv, diff;
    longint unsigned e_n, v_n, r1, r2, h, ha, rem, dmax, spd, lim, dn, den, dm, q;
    longint unsigned dpos, dneg;
    bit snap;
    dpos = 0;
    dneg = 0;
    snap = 1'b0;
    for (int i = 0; i < 3; i++) goal[i] = longint'($signed(w.val[i]));
    if (w.op == OP_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        pos_m[i] = goal[i];
        vel_m[i] = longint'($signed(w.val[3+i]));
        acc[i] = 0;
      end
    end else begin
      for (int i = 0; i < 3; i++) err[i] = sat_w(goal[i] - pos_m[i]);
      e_n = length3(err[0], err[1], err[2]);
      v_n = length3(vel_m[0], vel_m[1], vel_m[2]);
      // Deceleration-bounded speed toward the target
      r1 = root_floor(add_wide(mul_wide(e_n, accel_m), mul_wide(e_n, accel_m)));
      h = mul_fix(v_n, dt_m, FB + 1);
      ha = mul_fix(h, accel_m, FB);
      rem = e_n > ha ? e_n - ha : 0;
      r2 = root_floor(mul_wide(2 * rem, 64'd1 << FB));
      dmax = (r1 + r2) >> 1;
      spd = speed_m < dmax ? speed_m : dmax;
      for (int i = 0; i < 3; i++) begin
        want[i] = signed_of(err[i] < 0, scale_ratio(mag(err[i]), spd, e_n));
        dv[i] = sat_w(want[i] - vel_m[i]);
      end
      // Limit the velocity change
      lim = mul_fix(accel_m, dt_m, FB);
      dn = length3(dv[0], dv[1], dv[2]);
      for (int i = 0; i < 3; i++) begin
        if (dn < lim) vn[i] = want[i];
        else vn[i] = sat_w(vel_m[i] + signed_of(dv[i] < 0,
                                                scale_ratio(mag(dv[i]), lim, dn)));
      end
      // Advance and test for crossing the target plane
      for (int i = 0; i < 3; i++) begin
        adv = signed_of(vn[i] < 0, mul_fix(mag(vn[i]), dt_m, FB));
        nxt[i] = sat_w(pos_m[i] + adv);
        a = sat_w(nxt[i] - goal[i]);
        b = sat_w(pos_m[i] - goal[i]);
        if ((a < 0) != (b < 0) && a != 0 && b != 0)
          dneg = add_wide(dneg, mul_wide(mag(a), mag(b)));
        else
          dpos = add_wide(dpos, mul_wide(mag(a), mag(b)));
      end
      snap = dneg > dpos;
      den = dt_m > DT_MIN ? dt_m : DT_MIN;
      for (int i = 0; i < 3; i++) begin
        diff = vn[i] - vel_m[i];
        dm = mag(diff);
        if (dm > (U64MAX >> FB)) q = MAGMAX + 1;
        else q = (dm << FB) / den;
        acc[i] = signed_of(diff < 0, q);
      end
      for (int i = 0; i < 3; i++) begin
        pos_m[i] = snap ? goal[i] : nxt[i];
        vel_m[i] = snap ? 0 : vn[i];
      end
    end
    for (int i = 0; i < 3; i++) begin
      res.val[i]   = pos_m[i][31:0];
      res.val[3+i] = vel_m[i][31:0];
      res.val[6+i] = acc[i][31:0];
    end
    res.snap = snap;
    return res;
  endfunction

  // ---------------------------------------------------------------- sender
  logic s_took;
  int   burst_left = 0, gap_left = 0;

  always @(posedge clk_i) s_took <= s_axis_tvalid_i && s_axis_tready_o;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (s_axis_tvalid_i && !s_took) begin
      // hold the offered word
    end else begin
      if (s_took) void'(pending_words.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        s_axis_tdata_i  <= pending_words[0].val;
        s_axis_tuser_i  <= pending_words[0].op;
        s_axis_tvalid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int hold_done = 0, hold_left = 0, mode_left = 0, stall_mode = 0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (hold_done < hold_reqs) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left  = $urandom_range(50, 3000);
        stall_mode = $urandom_range(0, 2);
      end
      mode_left--;
      case (stall_mode)
        0: begin
          m_axis_tready_i <= 1'b1;
        end
        1: begin
          m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          m_axis_tready_i <= ($urandom_range(0, 9) == 0);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    motion_t got, exp_m;
    if (rst_ni) begin
      // Track register writes and predict each accepted word
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SPEED: speed_m = cfg_data_i;
          CFG_ACCEL: accel_m = cfg_data_i;
          CFG_STEP:  dt_m    = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_motion.push_back(advance_trajectory({s_axis_tuser_i, s_axis_tdata_i}));
      // Compare each delivered word with the oldest expectation
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tdata_o, m_axis_tuser_o};
        if (expected_motion.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected word %h", $realtime, got);
        end else begin
          exp_m = expected_motion.pop_front();
          for (int i = 0; i < 9; i++) begin
            if (got.val[i] !== exp_m.val[i]) begin
              fail_cnt++;
              $display("%0t: field %0d expected %h actual %h", $realtime, i,
                       exp_m.val[i], got.val[i]);
            end
          end
          if (got.snap !== exp_m.snap) begin
            fail_cnt++;
            $display("%0t: snapped expected %b actual %b", $realtime, exp_m.snap,
                     got.snap);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_motion.size() > 0 || s_axis_tvalid_i)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(logic [30:0] spd, logic [30:0] acc, logic [30:0] dt);
    write_reg(CFG_SPEED, spd);
    write_reg(CFG_ACCEL, acc);
    write_reg(CFG_STEP, dt);
  endtask

  task automatic queue_word(logic op, logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                            logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    stim_word_t w;
    w.op = op;
    w.val = {vz, vy, vx, gz, gy, gx};
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] rand_coord(int spread);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  // Load a start state, then walk towards a few targets in turn
  task automatic queue_run(int spread);
    int steps;
    logic [31:0] gx, gy, gz;
    queue_word(OP_LOAD, rand_coord(spread), rand_coord(spread), rand_coord(spread),
               rand_coord(spread / 4), rand_coord(spread / 4), rand_coord(spread / 4));
    gx = rand_coord(spread);
    gy = rand_coord(spread);
    gz = rand_coord(spread);
    steps = $urandom_range(1, 6);
    for (int k = 0; k < steps; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        gx = rand_coord(spread);
        gy = rand_coord(spread);
        gz = rand_coord(spread);
      end
      queue_word(OP_STEP, gx, gy, gz, $urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin
    int sent, spread;
    logic [30:0] rs, ra, rt;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = OP_STEP;
    m_axis_tready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SPEED;
    cfg_data_i = '0;
    speed_m = 64'd1 << FB;
    accel_m = 64'd1 << FB;
    dt_m = DT_RESET;
    for (int i = 0; i < 3; i++) begin
      pos_m[i] = 0;
      vel_m[i] = 0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset settings, zero error, extremes, load then step
    queue_word(OP_STEP, 0, 0, 0, 32'hFFFF_FFFF, 0, 0);
    queue_word(OP_STEP, 32'h0001_0000, 0, 0, 0, 0, 0);
    queue_word(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 0,
               32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_word(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0);
    queue_word(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
    queue_word(OP_LOAD, 0, 0, 0, 0, 0, 0);
    queue_word(OP_STEP, 32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_0008, 0, 0, 0);
    queue_word(OP_STEP, 32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_0008, 0, 0, 0);
    wait_drained();

    // Extremes of the registers, long receiver hold while words keep coming
    set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_word(OP_LOAD, 0, 0, 0, 32'h0001_0000, 0, 0);
    queue_word(OP_STEP, 32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000, 0, 0, 0);
    queue_word(OP_STEP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    queue_word(OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_word(OP_STEP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    hold_reqs++;
    for (int k = 0; k < 5; k++) queue_word(OP_LOAD, $urandom(), $urandom(), $urandom(),
                                           $urandom(), $urandom(), $urandom());
    wait_drained();

    // Zero limits: velocity change is blocked, zero dt hits the acceleration floor
    set_regs(0, 0, 0);
    queue_word(OP_LOAD, 0, 0, 0, 32'h0003_0000, 32'hFFFE_0000, 0);
    queue_word(OP_STEP, 32'h0100_0000, 0, 0, 0, 0, 0);
    queue_word(OP_STEP, 0, 0, 0, 0, 0, 0);
    wait_drained();
    set_regs(31'd65536, 31'd0, 31'd6553);
    queue_word(OP_LOAD, 0, 0, 0, 32'h0002_0000, 0, 0);
    queue_word(OP_STEP, 32'h0000_1000, 0, 0, 0, 0, 0);
    wait_drained();

    // Random phases, each with its own settings
    sent = 0;
    while (sent < 930) begin
      case ($urandom_range(0, 3))
        0: begin
          rs = $urandom();
          ra = $urandom();
          rt = $urandom();
          spread = 32'h7FFF_FFFF;
        end
        default: begin
          rs = $urandom_range(1 << 14, 1 << 22);
          ra = $urandom_range(1 << 14, 1 << 24);
          rt = $urandom_range(600, 1 << 16);
          spread = $urandom_range(1 << 12, 1 << 20);
        end
      endcase
      set_regs(rs, ra, rt);
      for (int r = 0; r < 20; r++) begin
        queue_run(spread);
        if ($urandom_range(0, 5) == 0)
          queue_word($urandom_range(0, 1), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom());
        sent = sent + 5;
      end
      if ($urandom_range(0, 4) == 0) hold_reqs++;
      wait_drained();
    end

    repeat (4000) @(posedge clk_i);
    if (fail_cnt == 0 && expected_motion.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
